// File: rtl/core/dwd_pkg.sv
// Shared types and constants for the decimal64 word decoder pipeline.
// No dependencies; every other file in rtl/core except dwd_checker imports this package.
package dwd_pkg;

    // Word layout
    localparam int WORD_W        = 64;
    localparam int COMB_W        = 5;
    localparam int EXP_CONT_W    = 8;
    localparam int CONT_W        = 50;
    localparam int EXP_W         = 11;
    localparam int LEAD_W        = 4;

    // Coefficient digits carried by the shift-and-add-3 converter
    localparam int DIGITS        = 16;
    localparam int BCD_W         = 4 * DIGITS;

    // Converter split: CONT_W shift steps spread over equal stages
    localparam int BITS_PER_STAGE = 5;
    localparam int DABBLE_STAGES  = CONT_W / BITS_PER_STAGE;

    // Combination field codes
    localparam logic [COMB_W-1:0] COMB_INF   = 5'h1E;
    localparam logic [COMB_W-1:0] COMB_NAN   = 5'h1F;
    localparam logic [1:0]        COMB_LARGE = 2'b11;

    localparam logic [EXP_W-1:0]  EXP_BIAS   = 11'd398;
    localparam logic [3:0]        DIGIT_FIX  = 4'd3;
    localparam logic [3:0]        DIGIT_HALF = 4'd5;
    localparam logic [4:0]        DIGIT_TEN  = 5'd10;

    // One item as it moves down the pipeline
    typedef struct packed {
        logic                     sign;
        logic                     is_inf;
        logic                     is_nan;
        logic signed [EXP_W-1:0]  expo;
        logic [LEAD_W-1:0]        lead;
        logic [BCD_W-1:0]         bcd;
        logic [CONT_W-1:0]        bin;
    } dwd_beat_t;

endpackage

// File: rtl/core/dwd_unpack.sv
// First pipeline stage: splits the raw word into sign, class, exponent and coefficient parts.
// Depends on dwd_pkg.
module dwd_unpack (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      move,
    input  logic                      valid_in,
    input  logic [63:0]               raw_word,
    output logic                      valid_reg,
    output dwd_pkg::dwd_beat_t        beat_reg
);
    import dwd_pkg::*;

    logic [COMB_W-1:0]     comb;
    logic [EXP_CONT_W-1:0] exp_tail;
    logic [CONT_W-1:0]     cont;
    logic [1:0]            exp_msbs;
    logic [LEAD_W-1:0]     lead;
    logic                  special;
    logic                  coeff_zero;
    logic [EXP_W-1:0]      biased;
    dwd_beat_t             beat_next;

    assign comb     = raw_word[WORD_W-2 -: COMB_W];
    assign exp_tail = raw_word[CONT_W +: EXP_CONT_W];
    assign cont     = raw_word[CONT_W-1:0];

    // Pick exponent high bits and lead digit from the combination field
    always_comb
    begin
        if (comb[COMB_W-1 -: 2] == COMB_LARGE)
        begin
            exp_msbs = comb[2:1];
            lead     = {1'b1, 2'b00, comb[0]};
        end
        else
        begin
            exp_msbs = comb[4:3];
            lead     = {1'b0, comb[2:0]};
        end
    end

    assign special    = (comb == COMB_INF) || (comb == COMB_NAN);
    assign coeff_zero = (lead == '0) && (cont == '0);
    assign biased     = {1'b0, exp_msbs, exp_tail};

    // Build the beat; specials and zero coefficients drop the exponent
    always_comb
    begin
        beat_next        = '0;
        beat_next.sign   = raw_word[WORD_W-1];
        beat_next.is_inf = (comb == COMB_INF);
        beat_next.is_nan = (comb == COMB_NAN);
        if (!special)
        begin
            beat_next.lead = lead;
            beat_next.bin  = cont;
            if (!coeff_zero)
            begin
                beat_next.expo = biased - EXP_BIAS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (move)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

// File: rtl/core/dwd_dabble_stage.sv
// One stage of the binary to BCD converter: BITS_PER_STAGE shift-and-add-3 steps.
// Depends on dwd_pkg.
module dwd_dabble_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      move,
    input  logic                      valid_in,
    input  dwd_pkg::dwd_beat_t        beat_in,
    output logic                      valid_reg,
    output dwd_pkg::dwd_beat_t        beat_reg
);
    import dwd_pkg::*;

    dwd_beat_t beat_next;

    // Correct every digit of five or more, then shift in the next binary bit
    function automatic dwd_beat_t dabble_step(input dwd_beat_t b);
        dwd_beat_t  r;
        logic [3:0] d;
        r = b;
        for (int k = 0; k < DIGITS; k++)
        begin
            d = r.bcd[4*k +: 4];
            if (d >= DIGIT_HALF)
            begin
                r.bcd[4*k +: 4] = d + DIGIT_FIX;
            end
        end
        r.bcd = {r.bcd[BCD_W-2:0], r.bin[CONT_W-1]};
        r.bin = {r.bin[CONT_W-2:0], 1'b0};
        return r;
    endfunction

    always_comb
    begin
        beat_next = beat_in;
        for (int s = 0; s < BITS_PER_STAGE; s++)
        begin
            beat_next = dabble_step(beat_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (move)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

// File: rtl/core/dwd_finish.sv
// Last stage: folds the lead digit into digit fifteen and holds the output beat.
// Depends on dwd_pkg.
module dwd_finish (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      move,
    input  logic                      valid_in,
    input  dwd_pkg::dwd_beat_t        beat_in,
    output logic                      valid_reg,
    output logic                      sign_reg,
    output logic                      inf_reg,
    output logic                      nan_reg,
    output logic signed [10:0]        expo_reg,
    output logic                      top_reg,
    output logic [63:0]               low_reg
);
    import dwd_pkg::*;

    logic [4:0]       sum;
    logic             top_next;
    logic [3:0]       digit_next;
    logic [BCD_W-1:0] low_next;

    // Add lead at the 10^15 place; the sum never exceeds ten
    assign sum = {1'b0, beat_in.lead} + {1'b0, beat_in.bcd[BCD_W-1 -: 4]};

    always_comb
    begin
        if (sum >= DIGIT_TEN)
        begin
            top_next   = 1'b1;
            digit_next = 4'(sum - DIGIT_TEN);
        end
        else
        begin
            top_next   = 1'b0;
            digit_next = sum[3:0];
        end
        low_next = {digit_next, beat_in.bcd[BCD_W-5:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (move)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            sign_reg <= beat_in.sign;
            inf_reg  <= beat_in.is_inf;
            nan_reg  <= beat_in.is_nan;
            expo_reg <= beat_in.expo;
            top_reg  <= top_next;
            low_reg  <= low_next;
        end
    end

endmodule

// File: rtl/core/decimal64_word_decoder_core.sv
// Decimal64 interchange word decoder: sign, class, unbiased exponent, 17-digit BCD coefficient.
// Depends on dwd_pkg, dwd_unpack, dwd_dabble_stage and dwd_finish.
//
// Usage:
//   Input channel carries raw_word on in_valid / in_stall; output channel carries
//   sign_negative, is_infinity, is_nan, unbiased_exponent, coeff_top_digit and
//   coeff_low_bcd on out_valid / out_stall. A beat moves when valid is high and
//   stall is low at a rising clock edge.
//   From input beat to output beat a word passes one unpack stage, ten
//   converter stages of five shift-and-add-3 steps each (the 50-bit
//   continuation sets the depth), and one output stage.
//   Throughput is one word per cycle while out_stall is low; words are independent.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles close up under a stall and in_stall rises only when all twelve
//   stages hold a word and the output beat is stalled. A stalled output beat
//   holds its value.
//   rst_n clears every stage valid bit asynchronously; data registers are not
//   reset. There is no configuration and no state between words.
module decimal64_word_decoder_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [63:0]          raw_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 sign_negative,
    output logic                 is_infinity,
    output logic                 is_nan,
    output logic signed [10:0]   unbiased_exponent,
    output logic                 coeff_top_digit,
    output logic [63:0]          coeff_low_bcd
);
    import dwd_pkg::*;

    logic                     unpack_valid;
    logic                     unpack_move;
    dwd_beat_t                unpack_beat;
    logic [DABBLE_STAGES-1:0] dab_valid;
    logic [DABBLE_STAGES-1:0] dab_move;
    dwd_beat_t                dab_beat [DABBLE_STAGES];
    logic                     fin_move;

    // Advance chain: a stage moves when empty or when its successor moves
    assign fin_move = !out_valid || !out_stall;

    always_comb
    begin
        dab_move[DABBLE_STAGES-1] = !dab_valid[DABBLE_STAGES-1] || fin_move;
        for (int i = DABBLE_STAGES - 2; i >= 0; i--)
        begin
            dab_move[i] = !dab_valid[i] || dab_move[i+1];
        end
    end

    assign unpack_move = !unpack_valid || dab_move[0];
    assign in_stall    = !unpack_move;

    dwd_unpack u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .move      (unpack_move),
        .valid_in  (in_valid),
        .raw_word  (raw_word),
        .valid_reg (unpack_valid),
        .beat_reg  (unpack_beat)
    );

    // Converter stages
    for (genvar g = 0; g < DABBLE_STAGES; g++)
    begin : g_dab
        if (g == 0)
        begin : g_first
            dwd_dabble_stage u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .move      (dab_move[g]),
                .valid_in  (unpack_valid),
                .beat_in   (unpack_beat),
                .valid_reg (dab_valid[g]),
                .beat_reg  (dab_beat[g])
            );
        end
        else
        begin : g_rest
            dwd_dabble_stage u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .move      (dab_move[g]),
                .valid_in  (dab_valid[g-1]),
                .beat_in   (dab_beat[g-1]),
                .valid_reg (dab_valid[g]),
                .beat_reg  (dab_beat[g])
            );
        end
    end

    dwd_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .move      (fin_move),
        .valid_in  (dab_valid[DABBLE_STAGES-1]),
        .beat_in   (dab_beat[DABBLE_STAGES-1]),
        .valid_reg (out_valid),
        .sign_reg  (sign_negative),
        .inf_reg   (is_infinity),
        .nan_reg   (is_nan),
        .expo_reg  (unbiased_exponent),
        .top_reg   (coeff_top_digit),
        .low_reg   (coeff_low_bcd)
    );

endmodule

// File: rtl/core/dwd_checker.sv
// Port-level checks for decimal64_word_decoder_core, attached by bind.
// Depends only on the top level's ports.
module dwd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic [63:0]          raw_word,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 sign_negative,
    input logic                 is_infinity,
    input logic                 is_nan,
    input logic signed [10:0]   unbiased_exponent,
    input logic                 coeff_top_digit,
    input logic [63:0]          coeff_low_bcd
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(coeff_low_bcd)
            && $stable(unbiased_exponent) && $stable(coeff_top_digit))
        else $error("stalled output beat changed");

    // Backpressure reaches the input only through a stalled output beat
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // Class flags are exclusive
    a_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_infinity && is_nan))
        else $error("infinity and NaN both set");

    // Specials carry no exponent or coefficient
    a_special: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (is_infinity || is_nan) |->
            unbiased_exponent == 11'sd0 && !coeff_top_digit && coeff_low_bcd == 64'd0)
        else $error("special value with nonzero fields");

    // A zero coefficient forces the exponent to zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !coeff_top_digit && coeff_low_bcd == 64'd0 |->
            unbiased_exponent == 11'sd0)
        else $error("zero coefficient with nonzero exponent");

endmodule

bind decimal64_word_decoder_core dwd_checker u_dwd_checker (.*);
